[rtl/mpqd_pkg.sv]
// Shared types and codes for the min priority queue.
package mpqd_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_QUERY3 = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_DUP      = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_MATCH = 2'd1,
    PH_SHIFT = 2'd2,
    PH_OUT   = 2'd3
  } phase_e;

  // Operation broadcast from the controller to every cell.
  typedef struct packed {
    logic ins;   // insert shift: cells above the slot take left neighbor
    logic del;   // delete shift: cells at or above the hit take right neighbor
  } cell_op_t;

endpackage

[rtl/mpqd_if.sv]
// Valid/ready channel interface carrying a generic payload.
interface mpqd_if #(
  parameter int unsigned W = 8
) (
  input logic clk_i
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/min_priority_queue_with_delete_core.sv]
// Min priority queue with delete by key, built as a sorted chain of cells.
//
// Channels: req (sink) carries cmd and key_value; rsp (source) carries
// min_key, entry_count and status. One response per request, in order.
// Keys live in a row of DEPTH cells kept sorted ascending; cell 0 holds the
// minimum. Every cell compares its key with the request key in parallel, so
// insert finds its slot and delete finds its key in one compare step; the
// chain then moves by one place in the shift phase, each moving cell taking
// its neighbor's key or, at the insert slot, the request key.
// The response becomes valid after the match and shift phases, independent
// of DEPTH. One request is in flight at a time, so a new request is taken
// only after the response to the last one is delivered.
// Reset clears the entry count and control; cell contents need no reset.
// When the receiver stalls, the response is held and no new request is taken
// until it is delivered.
module min_priority_queue_with_delete_core #(
  parameter int unsigned DEPTH    = 256,
  parameter int unsigned KEY_BITS = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  mpqd_if.sink   req_i,
  mpqd_if.source rsp_o
);
  import mpqd_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);

  // Request payload: {cmd, key_value}; response: {min_key, entry_count, status}.
  logic [1:0]          in_cmd;
  logic [KEY_BITS-1:0] in_key;
  assign in_cmd = req_i.data[KEY_BITS+1:KEY_BITS];
  assign in_key = req_i.data[KEY_BITS-1:0];

  phase_e              phase_q, phase_d;
  logic [1:0]          cmd_q;
  logic [KEY_BITS-1:0] key_q;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [2:0]          status_q, status_d;
  logic [KEY_BITS-1:0] min_key;
  logic                do_ins_q, do_ins_d, do_del_q, do_del_d;
  logic [DEPTH-1:0]    gt_q, eq_q;

  logic [KEY_BITS-1:0] cell_key [DEPTH];
  logic [DEPTH-1:0]    gt_w, eq_w, valid_w;
  cell_op_t            op;

  assign op.ins = do_ins_q;
  assign op.del = do_del_q;

  // Build the chain of cells.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [KEY_BITS-1:0] left_k, right_k;
    logic                sh, ld;
    if (g == 0) begin : g_l0
      assign left_k = '0;
    end else begin : g_ln
      assign left_k = cell_key[g-1];
    end
    if (g == DEPTH - 1) begin : g_rl
      assign right_k = '0;
    end else begin : g_rn
      assign right_k = cell_key[g+1];
    end
    assign valid_w[g] = CW'(g) < cnt_q;
    // Insert: slot is the first valid cell greater than key, or cnt.
    if (g == 0) begin : g_s0
      assign ld = do_ins_q && (gt_q[g] || !valid_w[g]);
    end else begin : g_sn
      assign ld = do_ins_q && (gt_q[g] || !valid_w[g])
                  && !(gt_q[g-1] || !valid_w[g-1]);
    end
    // Delete: hit cell and all above take right; insert: above slot take left.
    assign sh = (phase_q == PH_SHIFT) &&
                ((do_ins_q && (gt_q[g] || !valid_w[g]) && !ld) ||
                 (do_del_q && (gt_q[g] || eq_q[g] || !valid_w[g])));
    mpqd_cell #(.KEY_BITS(KEY_BITS)) u_cell (
      .clk_i      (clk_i),
      .op_i       (op),
      .shift_en_i (sh),
      .load_en_i  (ld && (phase_q == PH_SHIFT)),
      .req_key_i  (key_q),
      .left_key_i (left_k),
      .right_key_i(right_k),
      .key_o      (cell_key[g]),
      .gt_o       (gt_w[g]),
      .eq_o       (eq_w[g])
    );
  end

  // Minimum is cell 0 once the shift settles, zero when empty.
  assign min_key = (cnt_q != '0) ? cell_key[0] : '0;

  assign req_i.ready = (phase_q == PH_IDLE);
  assign rsp_o.valid = (phase_q == PH_OUT);
  assign rsp_o.data  = {min_key, 9'(cnt_q), status_q};

  // Sequence one request through match, shift and output.
  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    status_d = status_q;
    do_ins_d = do_ins_q;
    do_del_d = do_del_q;
    case (phase_q)
      PH_IDLE: begin
        if (req_i.valid) begin
          phase_d = PH_MATCH;
        end
      end
      PH_MATCH: begin
        do_ins_d = 1'b0;
        do_del_d = 1'b0;
        status_d = ST_OK;
        if (cmd_q == CMD_INSERT) begin
          if (cnt_q >= CW'(DEPTH)) begin
            status_d = ST_FULL;
          end else if (|(eq_w & valid_w)) begin
            status_d = ST_DUP;
          end else begin
            do_ins_d = 1'b1;
          end
        end else if (cmd_q == CMD_DELETE) begin
          if (cnt_q == '0) begin
            status_d = ST_EMPTY;
          end else if (!(|(eq_w & valid_w))) begin
            status_d = ST_NOTFOUND;
          end else begin
            do_del_d = 1'b1;
          end
        end else if (cnt_q == '0) begin
          status_d = ST_EMPTY;
        end
        phase_d = PH_SHIFT;
      end
      PH_SHIFT: begin
        // Count moves with the shift so validity during shift uses the old count.
        if (do_ins_q) begin
          cnt_d = cnt_q + CW'(1);
        end else if (do_del_q) begin
          cnt_d = cnt_q - CW'(1);
        end
        phase_d = PH_OUT;
      end
      PH_OUT: begin
        do_ins_d = 1'b0;
        do_del_d = 1'b0;
        if (rsp_o.ready) begin
          phase_d = PH_IDLE;
        end
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      cnt_q    <= '0;
      do_ins_q <= 1'b0;
      do_del_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      do_ins_q <= do_ins_d;
      do_del_q <= do_del_d;
    end
  end

  // Latch request, compare flags and response status.
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      cmd_q <= in_cmd;
      key_q <= in_key;
    end
    if (phase_q == PH_MATCH) begin
      gt_q     <= gt_w;
      eq_q     <= eq_w & valid_w;
      status_q <= status_d;
    end
  end
endmodule

[rtl/mpqd_cell.sv]
// One cell of the sorted array: holds one key and compares against the request key.
module mpqd_cell #(
  parameter int unsigned KEY_BITS = 32
) (
  input  logic                clk_i,
  input  mpqd_pkg::cell_op_t  op_i,
  input  logic                shift_en_i,
  input  logic                load_en_i,
  input  logic [KEY_BITS-1:0] req_key_i,
  input  logic [KEY_BITS-1:0] left_key_i,
  input  logic [KEY_BITS-1:0] right_key_i,
  output logic [KEY_BITS-1:0] key_o,
  output logic                gt_o,
  output logic                eq_o
);
  import mpqd_pkg::*;

  logic [KEY_BITS-1:0] key_q;
  logic [KEY_BITS-1:0] key_d;

  // Compare stored key against request key in signed order.
  assign gt_o  = $signed(key_q) > $signed(req_key_i);
  assign eq_o  = key_q == req_key_i;
  assign key_o = key_q;

  // Take the request key, or a neighbor's key when the chain shifts.
  always_comb begin
    key_d = key_q;
    if (load_en_i) begin
      key_d = req_key_i;
    end else if (shift_en_i && op_i.ins) begin
      key_d = left_key_i;
    end else if (shift_en_i && op_i.del) begin
      key_d = right_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end
endmodule
